[rtl/core/pulse_width_burst_capture_macros.svh]
// assertion helpers shared by the capture rtl
// each check samples on clk and is off while arst_n is low
`ifndef PULSE_WIDTH_BURST_CAPTURE_MACROS_SVH
`define PULSE_WIDTH_BURST_CAPTURE_MACROS_SVH
`ifndef ASSERT_OFF
`define PWBC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define PWBC_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define PWBC_ASSERT(label, prop, msg)
`define PWBC_NEVER(label, cond, msg)
`endif
`endif

[rtl/core/pwbc_pkg.sv]
`default_nettype none
package pwbc_pkg;

	// item operation codes
	typedef enum logic {
		OP_EDGE = 1'b0,
		OP_POLL = 1'b1
	} op_t;

	// configuration register indexes
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_DELTA = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_DELTA = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_COUNT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_COUNT = 3'd4;

	// field widths
	localparam int TIME_W  = 32;
	localparam int DELTA_W = 16;
	localparam int COUNT_W = 7;

	// saturation value of a stored gap
	localparam logic [DELTA_W-1:0] SAT_GAP = 16'hFFFF;

endpackage
`default_nettype wire

[rtl/core/pwbc_ram.sv]
`default_nettype none
module pwbc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read, holds while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

[rtl/core/pulse_width_burst_capture.sv]
// Pulse width burst capture: edge and poll items carry a microsecond timestamp;
// gaps between edges are saturated to 16 bits and kept in a delta memory of
// MAX_DELTAS entries, and each closed burst long enough to keep is played out
// one delta per beat with last on its final delta. When an item is taken its
// elapsed time is formed by one 32-bit subtract; the compares and the memory
// write follow in the next cycle. While enable is low an item is taken and
// dropped. A burst of N deltas starts with a memory read in S_LOAD, then plays
// out N beats at one per cycle from the memory's single read port while
// out_ready is high; no new item is taken until the last beat leaves.
// Configuration writes are taken in every cycle. The delta memory needs no
// clearing after reset.
`default_nettype none
`include "pulse_width_burst_capture_macros.svh"
module pulse_width_burst_capture #(
	parameter int MAX_DELTAS = 64
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// configuration
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [pwbc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [pwbc_pkg::CFG_DATA_W-1:0]    cfg_data,
	// input items
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic                               operation,
	input  wire logic [pwbc_pkg::TIME_W-1:0]        time_us,
	// result items
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic      [pwbc_pkg::DELTA_W-1:0]       delta_us,
	output logic                                    last
);

	import pwbc_pkg::*;

	localparam int ADDR_W = $clog2(MAX_DELTAS);
	localparam int CNT_W  = $clog2(MAX_DELTAS + 1);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_EVAL = 4'b0010,
		S_LOAD = 4'b0100,
		S_EMIT = 4'b1000
	} state_t;

	state_t               state_q;
	logic                 enable_q;
	logic [DELTA_W-1:0]   min_delta_q;
	logic [DELTA_W-1:0]   max_delta_q;
	logic [COUNT_W-1:0]   min_count_q;
	logic [COUNT_W-1:0]   max_count_q;

	logic                 armed_q;
	logic [TIME_W-1:0]    last_edge_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [CNT_W-1:0]     emit_len_q;
	logic [CNT_W-1:0]     rd_idx_q;
	logic                 last_q;

	op_t                  op_s1;
	logic [TIME_W-1:0]    time_s1;
	logic [TIME_W-1:0]    elapsed_s1;

	logic                 in_fire;
	logic                 is_edge;
	logic [DELTA_W-1:0]   gap;
	logic                 timeout_hit;
	logic                 push;
	logic [CNT_W-1:0]     new_cnt;
	logic                 close;
	logic                 keep;
	logic                 more;
	logic                 ram_we;
	logic                 ram_re;
	logic [ADDR_W-1:0]    ram_raddr;
	logic [DELTA_W-1:0]   ram_rdata;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_valid = (state_q == S_EMIT);
	assign delta_us  = ram_rdata;
	assign last      = last_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q    <= 1'b0;
			min_delta_q <= '0;
			max_delta_q <= SAT_GAP;
			min_count_q <= COUNT_W'(1);
			max_count_q <= COUNT_W'(64);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_ENABLE:    enable_q    <= cfg_data[0];
				REG_MIN_DELTA: min_delta_q <= cfg_data;
				REG_MAX_DELTA: max_delta_q <= cfg_data;
				REG_MIN_COUNT: min_count_q <= cfg_data[COUNT_W-1:0];
				REG_MAX_COUNT: max_count_q <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// first stage: capture item and time since the previous edge
	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_s1      <= op_t'(operation);
			time_s1    <= time_us;
			elapsed_s1 <= time_us - last_edge_q;
		end
	end

	// evaluation of the captured item
	assign is_edge     = (op_s1 == OP_EDGE);
	assign gap         = (elapsed_s1 >= TIME_W'(SAT_GAP)) ? SAT_GAP : elapsed_s1[DELTA_W-1:0];
	assign timeout_hit = (elapsed_s1 >= {{(TIME_W-DELTA_W){1'b0}}, max_delta_q});
	assign push        = armed_q && (is_edge || ((cnt_q != '0) && timeout_hit));
	assign new_cnt     = cnt_q + CNT_W'(1);
	assign close       = !is_edge || (gap < min_delta_q) || (gap >= max_delta_q) ||
	                     (COUNT_W'(new_cnt) >= max_count_q) ||
	                     (new_cnt >= CNT_W'(MAX_DELTAS));
	assign keep        = (COUNT_W'(new_cnt) >= min_count_q);
	assign more        = (rd_idx_q != emit_len_q);

	// memory port control
	assign ram_we    = (state_q == S_EVAL) && push;
	assign ram_re    = (state_q == S_LOAD) || ((state_q == S_EMIT) && out_ready && more);
	assign ram_raddr = (state_q == S_LOAD) ? '0 : rd_idx_q[ADDR_W-1:0];

	// sequencer and burst state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			armed_q     <= 1'b0;
			last_edge_q <= '0;
			cnt_q       <= '0;
			emit_len_q  <= '0;
			rd_idx_q    <= '0;
			last_q      <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_fire && enable_q) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					state_q <= S_IDLE;
					if (is_edge && !armed_q) begin
						armed_q     <= 1'b1;
						last_edge_q <= time_s1;
						cnt_q       <= '0;
					end else if (push) begin
						last_edge_q <= time_s1;
						if (!is_edge) begin
							armed_q <= 1'b0;
						end
						if (close) begin
							cnt_q <= '0;
							if (keep) begin
								emit_len_q <= new_cnt;
								state_q    <= S_LOAD;
							end
						end else begin
							cnt_q <= new_cnt;
						end
					end
				end
				S_LOAD: begin
					rd_idx_q <= CNT_W'(1);
					last_q   <= (emit_len_q == CNT_W'(1));
					state_q  <= S_EMIT;
				end
				S_EMIT: begin
					if (out_ready) begin
						if (more) begin
							rd_idx_q <= rd_idx_q + CNT_W'(1);
							last_q   <= ((rd_idx_q + CNT_W'(1)) == emit_len_q);
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// delta store
	pwbc_ram #(
		.WIDTH(DELTA_W),
		.DEPTH(MAX_DELTAS)
	) u_delta_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(cnt_q[ADDR_W-1:0]),
		.wdata(gap),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// checks
	`PWBC_NEVER(a_no_overlap, in_ready && out_valid, "input taken during burst readout")
	`PWBC_ASSERT(a_last_at_end, (out_valid && last) |-> !more, "last beat with deltas left")
	`PWBC_ASSERT(a_eval_once, (state_q == S_EVAL) |=> (state_q != S_EVAL), "item evaluated twice")
	`PWBC_NEVER(a_cnt_bound, cnt_q >= CNT_W'(MAX_DELTAS), "open burst count at store depth")
	`PWBC_ASSERT(a_len_nonzero, out_valid |-> (emit_len_q != '0), "readout of an empty burst")

endmodule
`default_nettype wire

[test/pulse_width_burst_capture_test.sv]
module pulse_width_burst_capture_test;
	import pwbc_pkg::*;

	localparam int DEPTH = 64;

	// one result beat
	typedef struct packed {
		logic [DELTA_W-1:0] delta;
		logic               last;
	} beat_t;

	// kinds of edge-to-edge gap the stimulus draws
	typedef enum int {
		GAP_FIT,
		GAP_SHORT,
		GAP_LONG,
		GAP_JUMP
	} gap_kind_t;

	// burst predictor and queue of beats still to come
	class burst_scoreboard;
		logic               enable;
		logic [DELTA_W-1:0] min_gap;
		logic [DELTA_W-1:0] max_gap;
		logic [COUNT_W-1:0] min_beats;
		logic [COUNT_W-1:0] max_beats;
		logic               armed;
		logic [TIME_W-1:0]  last_edge;
		logic [DELTA_W-1:0] gaps [DEPTH];
		int                 gap_count;
		beat_t              expected_beats [$];
		int                 mismatches;

		function new();
			enable = 1'b0;
			min_gap = '0;
			max_gap = SAT_GAP;
			min_beats = 7'd1;
			max_beats = 7'd64;
			armed = 1'b0;
			last_edge = '0;
			gap_count = 0;
			mismatches = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_ENABLE:    enable = data[0];
				REG_MIN_DELTA: min_gap = data;
				REG_MAX_DELTA: max_gap = data;
				REG_MIN_COUNT: min_beats = data[COUNT_W-1:0];
				REG_MAX_COUNT: max_beats = data[COUNT_W-1:0];
				default: ;
			endcase
		endfunction

		// store one gap and play out the burst if it closes with enough gaps
		function void store_gap(logic [DELTA_W-1:0] gap, bit timeout);
			bit    closes;
			beat_t b;
			int    k;
			if (gap_count < DEPTH) begin
				gaps[gap_count] = gap;
				gap_count++;
			end
			closes = timeout || gap < min_gap || gap >= max_gap ||
				gap_count >= max_beats || gap_count >= DEPTH;
			if (closes) begin
				if (gap_count >= min_beats) begin
					for (k = 0; k < gap_count; k++) begin
						b.delta = gaps[k];
						b.last = (k == gap_count - 1);
						expected_beats.insert(expected_beats.size(), b);
					end
				end
				gap_count = 0;
			end
		endfunction

		function void take_item(op_t op, logic [TIME_W-1:0] t);
			logic [TIME_W-1:0]  elapsed;
			logic [DELTA_W-1:0] gap;
			if (!enable)
				return;
			elapsed = t - last_edge;
			gap = (elapsed >= {16'h0, SAT_GAP}) ? SAT_GAP : elapsed[DELTA_W-1:0];
			if (op == OP_EDGE) begin
				if (!armed) begin
					armed = 1'b1;
					last_edge = t;
					gap_count = 0;
				end else begin
					last_edge = t;
					store_gap(gap, 1'b0);
				end
			end else if (armed && gap_count > 0 && elapsed >= {16'h0, max_gap}) begin
				// idle timeout ends the burst and disarms
				last_edge = t;
				store_gap(gap, 1'b1);
				armed = 1'b0;
				gap_count = 0;
			end
		endfunction

		function void check_beat(logic [DELTA_W-1:0] d, logic l);
			beat_t want;
			if (expected_beats.size() == 0) begin
				$display("%0t: beat with none pending: delta_us %h last %b", $time, d, l);
				mismatches++;
				return;
			end
			want = expected_beats[0];
			expected_beats.delete(0);
			if (d !== want.delta) begin
				$display("%0t: delta_us expected %h actual %h", $time, want.delta, d);
				mismatches++;
			end
			if (l !== want.last) begin
				$display("%0t: last expected %b actual %b", $time, want.last, l);
				mismatches++;
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic                  operation;
	logic [TIME_W-1:0]     time_us;
	logic                  out_valid;
	logic                  out_ready;
	logic [DELTA_W-1:0]    delta_us;
	logic                  last;

	burst_scoreboard sb = new();

	logic [TIME_W-1:0] now_us;
	bit                no_idle;
	int                recv_hold;

	pulse_width_burst_capture #(
		.MAX_DELTAS(DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.time_us(time_us),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.delta_us(delta_us),
		.last(last)
	);

	always #6 clk = ~clk;

	// watchdog
	initial begin
		#12000000;
		$display("FAIL");
		$finish;
	end

	// check every result beat
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_beat(delta_us, last);
	end

	// result side: random stalls, one long hold-off on request
	initial begin
		int wait_n;
		out_ready = 1'b0;
		@(posedge clk);
		forever begin
			if (recv_hold > 0) begin
				out_ready <= 1'b0;
				repeat (recv_hold) @(posedge clk);
				recv_hold = 0;
			end else begin
				wait_n = no_idle ? 0 : $urandom_range(0, 12);
				if (wait_n > 0) begin
					out_ready <= 1'b0;
					repeat (wait_n) @(posedge clk);
				end
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, data);
	endtask

	// write all registers plus one unused index; unused upper bits are random
	task automatic configure(logic en, logic [DELTA_W-1:0] lo, logic [DELTA_W-1:0] hi,
			logic [COUNT_W-1:0] fewest, logic [COUNT_W-1:0] most);
		write_reg(REG_ENABLE, {15'($urandom()), en});
		write_reg(REG_MIN_DELTA, lo);
		write_reg(REG_MAX_DELTA, hi);
		write_reg(REG_MIN_COUNT, {9'($urandom()), fewest});
		write_reg(REG_MAX_COUNT, {9'($urandom()), most});
		write_reg(REG_MAX_COUNT + 3'($urandom_range(1, 3)), 16'($urandom()));
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_item(op_t op, logic [TIME_W-1:0] t);
		int idle;
		idle = no_idle ? 0 : $urandom_range(0, 12);
		if (idle > 0) begin
			in_valid <= 1'b0;
			repeat (idle) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		time_us <= t;
		do @(posedge clk); while (!in_ready);
		sb.take_item(op, t);
	endtask

	task automatic send_step(op_t op, logic [TIME_W-1:0] dt);
		now_us = now_us + dt;
		send_item(op, now_us);
	endtask

	task automatic finish_items();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	// wait until all beats are out and any item still in evaluation is done
	task automatic wait_drained();
		while (sb.expected_beats.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic logic [TIME_W-1:0] pick_gap(gap_kind_t kind);
		case (kind)
			GAP_SHORT:
				return (sb.min_gap == 0) ? 0 : $urandom_range(0, int'(sb.min_gap) - 1);
			GAP_LONG:
				return $urandom_range(int'(sb.max_gap), int'(sb.max_gap) + 300);
			GAP_JUMP:
				return $urandom();
			default: begin
				if (sb.min_gap < sb.max_gap)
					return $urandom_range(int'(sb.min_gap), int'(sb.max_gap) - 1);
				return $urandom_range(0, 65535);
			end
		endcase
	endfunction

	// mostly in-range edges, with polls, short and long gaps and wild jumps
	task automatic run_mixed(int n);
		int i;
		int roll;
		for (i = 0; i < n; i++) begin
			roll = $urandom_range(0, 99);
			if (roll < 3)
				send_step(OP_POLL, pick_gap(GAP_JUMP));
			else if (roll < 15)
				send_step(OP_POLL, $urandom_range(0, int'(sb.max_gap) + 50));
			else if (roll < 20)
				send_step(OP_EDGE, pick_gap(GAP_JUMP));
			else if (roll < 28)
				send_step(OP_EDGE, pick_gap(GAP_SHORT));
			else if (roll < 34)
				send_step(OP_EDGE, pick_gap(GAP_LONG));
			else
				send_step(OP_EDGE, pick_gap(GAP_FIT));
		end
	endtask

	// a run of well-formed edges
	task automatic run_burst(int n);
		int i;
		for (i = 0; i < n; i++)
			send_step(OP_EDGE, pick_gap(GAP_FIT));
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		operation = OP_EDGE;
		time_us = '0;
		no_idle = 1'b0;
		recv_hold = 0;
		now_us = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: arming, wrap, saturation, timeout at the exact bound
		configure(1'b1, 16'd0, SAT_GAP, 7'd1, 7'd64);
		send_step(OP_POLL, 32'd5);
		now_us = 32'hFFFF_FFF0;
		send_item(OP_EDGE, now_us);
		send_step(OP_EDGE, 32'h20);
		send_step(OP_POLL, 32'd10);
		send_step(OP_EDGE, 32'd70000);
		send_step(OP_POLL, 32'd3);
		send_step(OP_EDGE, 32'd0);
		send_step(OP_POLL, 32'd65535);
		send_step(OP_POLL, 32'd100000);
		finish_items();
		wait_drained();

		// directed: short gap, count limit, dropped timeout burst
		configure(1'b1, 16'd100, 16'd1000, 7'd3, 7'd4);
		send_step(OP_EDGE, 32'd7);
		send_step(OP_EDGE, 32'd200);
		send_step(OP_EDGE, 32'd300);
		send_step(OP_EDGE, 32'd50);
		repeat (4) send_step(OP_EDGE, 32'd200);
		send_step(OP_EDGE, 32'd999);
		send_step(OP_POLL, 32'd999);
		send_step(OP_POLL, 32'd1);
		send_step(OP_EDGE, 32'd40);
		finish_items();
		wait_drained();

		// directed: zero max_count and zero max_delta close on every gap
		configure(1'b1, 16'd0, 16'd0, 7'd1, 7'd0);
		send_step(OP_EDGE, 32'd5);
		send_step(OP_EDGE, 32'd6);
		finish_items();
		wait_drained();

		// random: moderate window, pause for a full drain midway
		configure(1'b1, 16'd20, 16'd2000, 7'd2, 7'd8);
		run_mixed(15);
		finish_items();
		wait_drained();
		run_mixed(15);
		finish_items();
		wait_drained();

		// full bursts with a long receiver hold-off while items keep coming
		configure(1'b1, 16'd0, SAT_GAP, 7'd1, 7'd64);
		recv_hold = 400;
		run_burst(64);
		run_mixed(10);
		finish_items();
		wait_drained();

		// zero max_count with a random window
		configure(1'b1, 16'($urandom_range(0, 500)), 16'($urandom_range(500, 3000)),
			7'($urandom_range(0, 3)), 7'd0);
		run_mixed(10);
		finish_items();
		wait_drained();

		// max_count above the store depth, no idling
		no_idle = 1'b1;
		configure(1'b1, 16'd0, SAT_GAP, 7'd0, 7'd127);
		run_burst(65);
		finish_items();
		wait_drained();
		no_idle = 1'b0;

		// disabled: everything ignored
		configure(1'b0, 16'($urandom()), 16'($urandom()), 7'($urandom()), 7'($urandom()));
		run_mixed(10);
		finish_items();
		wait_drained();

		// min_count beyond any possible burst
		configure(1'b1, 16'd0, SAT_GAP, 7'd100, 7'd127);
		run_mixed(10);
		finish_items();
		wait_drained();

		// extreme window: every gap closes
		configure(1'b1, SAT_GAP, 16'd0, 7'd0, 7'd1);
		run_mixed(10);
		finish_items();

		while (sb.expected_beats.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.mismatches == 0 && sb.expected_beats.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
